FILE: hdl/rgbmf_pkg.sv
`timescale 1ns / 1ps

package rgbmf_pkg;

  // Fixed field widths
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 16;
  localparam int CFG_K_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIFF_W     = 27;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_WINDOW = 7;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

  // Register reset values
  localparam logic [CFG_W_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_H_W-1:0] RST_HEIGHT = 16'd480;
  localparam logic [CFG_K_W-1:0] RST_WINDOW = 3'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic issue;     // read next window cell
    logic bit_done;  // settle one bit of the rank search
    logic load;      // load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;       // accepted item yields a result
    logic border;     // result is a copy of the stored pixel
    logic cell_last;  // last window cell being read
    logic bit_last;   // last bit of the rank search
    logic out_free;   // result register can take a value
  } sts_t;

endpackage

FILE: hdl/rgb_window_median_filter.sv
`timescale 1ns / 1ps
// Pass-through result (border pixel or oversize window): the stored pixel goes via PASS and OUT.
// Median result: a rank search walks the k*k
// window cells through the single line-store read port once per result bit.
// One item in flight; an item that yields no result is taken without leaving the idle state.
// Reset (rst_n, synchronous, active low): registers to 640 x 480, k = 3, counters cleared.
module rgb_window_median_filter #(
  parameter int MAX_WIDTH  = rgbmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = rgbmf_pkg::DEF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgbmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rgbmf_pkg::PIX_W-1:0]      in_tdata,   // blue_in, green_in, red_in
  input  logic                             in_tuser,   // is_pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rgbmf_pkg::PIX_W-1:0]      out_tdata,  // blue_out, green_out, red_out
  output logic                             out_tlast,  // frame_last
  output logic                             out_tuser   // config_error
);

  rgbmf_pkg::cmd_t cmd;
  rgbmf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rgbmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rgbmf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hdl/rgbmf_ctrl.sv
`timescale 1ns / 1ps

module rgbmf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rgbmf_pkg::sts_t    sts,
  output rgbmf_pkg::cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PASS  = 6'b000010,
    S_MED   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_BIT   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_tvalid;
    cmd.issue    = (state_r == S_MED);
    cmd.bit_done = (state_r == S_BIT);
    cmd.load     = (state_r == S_OUT) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && sts.emit) begin
          state_nxt = sts.border ? S_PASS : S_MED;
        end
      end
      S_PASS:  state_nxt = S_OUT;
      S_MED: begin
        if (sts.cell_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_BIT;
      S_BIT:   state_nxt = sts.bit_last ? S_OUT : S_MED;
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/rgbmf_dp.sv
`timescale 1ns / 1ps

module rgbmf_dp #(
  parameter int MAX_WIDTH  = rgbmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_WINDOW = rgbmf_pkg::DEF_MAX_WINDOW
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [rgbmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [rgbmf_pkg::PIX_W-1:0]      in_tdata,
  input  logic                             in_tuser,
  input  rgbmf_pkg::cmd_t                  cmd,
  output rgbmf_pkg::sts_t                  sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rgbmf_pkg::PIX_W-1:0]      out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int HALF  = MAX_WINDOW / 2;
  localparam int DEPTH = 2 * HALF * MAX_WIDTH + 2 * HALF + 1;
  localparam int AW    = $clog2(DEPTH + 1);
  localparam int NCELL = MAX_WINDOW * MAX_WINDOW;
  localparam int NW    = $clog2(NCELL + 1);
  localparam int CHW   = rgbmf_pkg::CH_W;
  localparam int HW    = rgbmf_pkg::CFG_H_W;
  localparam int DW    = rgbmf_pkg::DIFF_W;

  // Configuration registers
  logic [rgbmf_pkg::CFG_W_W-1:0] cfg_w_r;
  logic [HW-1:0]                 cfg_h_r;
  logic [rgbmf_pkg::CFG_K_W-1:0] cfg_k_r;
  logic                          cfg_hit;

  // Frame position and ring pointers
  logic [CW-1:0] col_r, ox_r;
  logic [HW-1:0] row_r, oy_r;
  logic [DW-1:0] diff_r;
  logic [AW-1:0] wptr_r, eptr_r;

  // Window walk and rank search
  logic [AW-1:0]        ptr_r, start_r;
  logic [NW-1:0]        cell_r;
  logic [KW-1:0]        wcol_r;
  logic [2:0]           bit_r;
  logic                 acc_v_r;
  logic                 border_r;
  logic [CHW-1:0]       pfx_a_r [3];
  logic [CHW-1:0]       pfx_b_r [3];
  logic [NW-1:0]        cnt_a_r [3];
  logic [NW-1:0]        cnt_b_r [3];
  logic [CHW-1:0]       trial_a [3];
  logic [CHW-1:0]       trial_b [3];
  logic [CHW-1:0]       med     [3];
  logic [CHW:0]         msum    [3];

  // Line store
  logic [rgbmf_pkg::PIX_W-1:0] mem [DEPTH];
  logic [rgbmf_pkg::PIX_W-1:0] rd_q_r;

  // Result register
  logic                        out_v_r;
  logic [rgbmf_pkg::PIX_W-1:0] out_d_r;
  logic                        out_l_r, out_e_r;

  // Derived settings
  logic [CW-1:0] w_eff;
  logic [HW-1:0] ht_eff;
  logic [KW-1:0] k_eff, h;
  logic          err;
  logic [AW-1:0] lag, start, rowstep, ptr_adv;
  logic [AW:0]   ptr_sum;
  logic [NW-1:0] n_cells, rank_a, rank_b;
  logic          full, wr_now, wr_pix, frame_end;
  logic [AW-1:0] wptr_inc, eptr_inc;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg_w_r);
    end
    ht_eff = (cfg_h_r == '0) ? HW'(1) : cfg_h_r;
    if (cfg_k_r == '0) begin
      k_eff = KW'(1);
    end else if (32'(cfg_k_r) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(cfg_k_r);
    end
    h       = k_eff >> 1;
    err     = (32'(k_eff) > 32'(w_eff)) || (32'(k_eff) > 32'(ht_eff));
    lag     = err ? '0 : AW'(32'(h) * 32'(w_eff) + 32'(h));
    n_cells = NW'(32'(k_eff) * 32'(k_eff));
    rank_a  = n_cells >> 1;
    rank_b  = n_cells[0] ? rank_a : rank_a - NW'(1);
    rowstep = AW'(32'(w_eff) - 32'(k_eff) + 1);
    start   = (eptr_r >= lag) ? (eptr_r - lag) : AW'(32'(eptr_r) + DEPTH - 32'(lag));
  end

  // Next window cell address, wrapped round the ring
  always_comb begin
    ptr_sum = {1'b0, ptr_r} + {1'b0, ((wcol_r == k_eff - KW'(1)) ? rowstep : AW'(1))};
    ptr_adv = (ptr_sum >= (AW + 1)'(DEPTH)) ? AW'(ptr_sum - (AW + 1)'(DEPTH)) : AW'(ptr_sum);
  end

  assign wptr_inc = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
  assign eptr_inc = (eptr_r == AW'(DEPTH - 1)) ? '0 : eptr_r + AW'(1);

  assign full      = (row_r >= ht_eff);
  assign wr_now    = in_tuser && !full;
  assign wr_pix    = cmd.accept && wr_now;
  assign frame_end = (ox_r == w_eff - CW'(1)) && (oy_r == ht_eff - HW'(1));
  assign cfg_hit   = cfg_valid && ((cfg_index == rgbmf_pkg::REG_WIDTH) ||
                     (cfg_index == rgbmf_pkg::REG_HEIGHT) ||
                     (cfg_index == rgbmf_pkg::REG_WINDOW));

  // Status
  always_comb begin
    sts.emit = wr_now ? (({1'b0, diff_r} + (DW + 1)'(1)) > (DW + 1)'(lag))
                      : (full && (diff_r != '0));
    sts.border = err || (32'(ox_r) < 32'(h)) || (32'(ox_r) + 32'(h) >= 32'(w_eff)) ||
                 (32'(oy_r) < 32'(h)) || (32'(oy_r) + 32'(h) >= 32'(ht_eff));
    sts.cell_last = (cell_r == n_cells - NW'(1));
    sts.bit_last  = (bit_r == 3'd0);
    sts.out_free  = !out_v_r || out_tready;
  end

  // Per-channel trial values and median
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      trial_a[c] = pfx_a_r[c] | (CHW'(1) << bit_r);
      trial_b[c] = pfx_b_r[c] | (CHW'(1) << bit_r);
      msum[c]    = {1'b0, pfx_a_r[c]} + {1'b0, pfx_b_r[c]};
      med[c]     = msum[c][CHW:1];
    end
  end

  // Configuration, counters and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= rgbmf_pkg::RST_WIDTH;
      cfg_h_r <= rgbmf_pkg::RST_HEIGHT;
      cfg_k_r <= rgbmf_pkg::RST_WINDOW;
      col_r   <= '0;
      row_r   <= '0;
      ox_r    <= '0;
      oy_r    <= '0;
      diff_r  <= '0;
      wptr_r  <= '0;
      eptr_r  <= '0;
      out_v_r <= 1'b0;
      acc_v_r <= 1'b0;
    end else begin
      acc_v_r <= cmd.issue;
      if (cmd.load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_hit) begin
        case (cfg_index)
          rgbmf_pkg::REG_WIDTH:  cfg_w_r <= cfg_data[rgbmf_pkg::CFG_W_W-1:0];
          rgbmf_pkg::REG_HEIGHT: cfg_h_r <= cfg_data[HW-1:0];
          rgbmf_pkg::REG_WINDOW: cfg_k_r <= cfg_data[rgbmf_pkg::CFG_K_W-1:0];
          default: ;
        endcase
        col_r  <= '0;
        row_r  <= '0;
        ox_r   <= '0;
        oy_r   <= '0;
        diff_r <= '0;
        wptr_r <= '0;
        eptr_r <= '0;
      end else if (wr_pix) begin
        wptr_r <= wptr_inc;
        diff_r <= diff_r + DW'(1);
        if (col_r + CW'(1) >= w_eff) begin
          col_r <= '0;
          row_r <= row_r + HW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end else if (cmd.load) begin
        if (frame_end) begin
          col_r  <= '0;
          row_r  <= '0;
          ox_r   <= '0;
          oy_r   <= '0;
          diff_r <= '0;
          wptr_r <= '0;
          eptr_r <= '0;
        end else begin
          diff_r <= diff_r - DW'(1);
          eptr_r <= eptr_inc;
          if (ox_r == w_eff - CW'(1)) begin
            ox_r <= '0;
            oy_r <= oy_r + HW'(1);
          end else begin
            ox_r <= ox_r + CW'(1);
          end
        end
      end
    end
  end

  // Line store write and registered read
  always_ff @(posedge clk) begin
    if (wr_pix) begin
      mem[wptr_r] <= in_tdata;
    end
    rd_q_r <= mem[ptr_r];
  end

  // Window walk and rank search
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      border_r <= sts.border;
      start_r  <= start;
      ptr_r    <= sts.border ? eptr_r : start;
      cell_r   <= '0;
      wcol_r   <= '0;
      bit_r    <= 3'd7;
      for (int c = 0; c < 3; c++) begin
        pfx_a_r[c] <= '0;
        pfx_b_r[c] <= '0;
        cnt_a_r[c] <= '0;
        cnt_b_r[c] <= '0;
      end
    end else if (cmd.issue) begin
      ptr_r  <= ptr_adv;
      cell_r <= cell_r + NW'(1);
      wcol_r <= (wcol_r == k_eff - KW'(1)) ? '0 : wcol_r + KW'(1);
    end else if (cmd.bit_done) begin
      ptr_r  <= start_r;
      cell_r <= '0;
      wcol_r <= '0;
      bit_r  <= bit_r - 3'd1;
      for (int c = 0; c < 3; c++) begin
        if (cnt_a_r[c] <= rank_a) begin
          pfx_a_r[c] <= trial_a[c];
        end
        if (cnt_b_r[c] <= rank_b) begin
          pfx_b_r[c] <= trial_b[c];
        end
        cnt_a_r[c] <= '0;
        cnt_b_r[c] <= '0;
      end
    end
    // count cells below each trial value
    if (acc_v_r) begin
      for (int c = 0; c < 3; c++) begin
        cnt_a_r[c] <= cnt_a_r[c] + NW'(rd_q_r[c*CHW +: CHW] < trial_a[c]);
        cnt_b_r[c] <= cnt_b_r[c] + NW'(rd_q_r[c*CHW +: CHW] < trial_b[c]);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_d_r <= border_r ? rd_q_r : {med[2], med[1], med[0]};
      out_l_r <= frame_end;
      out_e_r <= err;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_e_r;

endmodule
